// ----- rtl/core/psc_pkg.sv -----
package psc_pkg;

    localparam int PORT_W = 16;
    localparam int IPADDR_W = 32;
    localparam int CNT_W = 16;
    localparam int EV_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_THRESHOLDS = 4;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_NUM_THRESHOLDS = 4;

    localparam logic [EV_W-1:0] EV_NONE = 2'd0;
    localparam logic [EV_W-1:0] EV_ESTABLISHED = 2'd1;
    localparam logic [EV_W-1:0] EV_RELEASED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LISTEN_PORT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOOK_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_0 = 3'd2;

    typedef struct packed {
        logic [PORT_W-1:0]   dest_port;
        logic [PORT_W-1:0]   source_port;
        logic [IPADDR_W-1:0] server_addr;
        logic [EV_W-1:0]     conn_event;
    } t_req;

    typedef struct packed {
        logic                port_hit;
        logic                kick;
        logic [CNT_W-1:0]    current_count;
        logic [IPADDR_W-1:0] addr_echo;
        logic                table_full;
    } t_rsp;

    typedef struct packed {
        logic [PORT_W-1:0] listen_port;
        logic              hook_mode;
    } t_cfg;

endpackage

// ----- rtl/core/per_server_connection_counter.sv -----
// Per-server connection counter.
// Request channel: drive i_req and pulse start; the request is taken at a
// rising edge with start high and busy low. busy stays high while the table
// is searched and updated; start is ignored meanwhile.
// Result channel: o_valid is high for one cycle with o_result; there is no
// back-pressure, the receiver must take it in that cycle.
// Flow: a request that is not counted (no port match or no event) gives
// its result in the cycle after acceptance and busy never rises, so such
// requests can follow every cycle. A counted request first scans the used
// entries in the SCAN state, stopping at the server's entry, and then writes
// back in the UPDATE state; a new server on a full table gives a table_full
// result straight from SCAN without write-back. The table memory is read one
// entry per cycle on its single read port.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write a register; write
// only while busy is low and no result is pending.
// Reset: synchronous, active low; clears the control and config registers and
// marks the table empty through a fill count, so no clearing pass is needed.
module per_server_connection_counter #(
    parameter int TABLE_ENTRIES = psc_pkg::DEF_TABLE_ENTRIES,
    parameter int NUM_THRESHOLDS = psc_pkg::DEF_NUM_THRESHOLDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  psc_pkg::t_req                  i_req,
    output logic                           o_valid,
    output psc_pkg::t_rsp                  o_result,
    input  logic                           i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psc_pkg::*;

    t_cfg                                 cfg;
    logic [NUM_THRESHOLDS-1:0][CNT_W-1:0] thr;

    psc_cfg #(.NUM_THRESHOLDS(NUM_THRESHOLDS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_thr      (thr)
    );

    psc_engine #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .NUM_THRESHOLDS (NUM_THRESHOLDS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .i_cfg    (cfg),
        .i_thr    (thr),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ----- rtl/core/psc_ram.sv -----
module psc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/psc_cfg.sv -----
module psc_cfg #(
    parameter int NUM_THRESHOLDS = psc_pkg::DEF_NUM_THRESHOLDS
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [psc_pkg::CFG_DATA_W-1:0]                  i_cfg_data,
    output psc_pkg::t_cfg                                   o_cfg,
    output logic [NUM_THRESHOLDS-1:0][psc_pkg::CNT_W-1:0]   o_thr
);
    import psc_pkg::*;

    t_cfg                                r_cfg;
    logic [NUM_THRESHOLDS-1:0][CNT_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_thr <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_LISTEN_PORT) begin
                r_cfg.listen_port <= i_cfg_data[PORT_W-1:0];
            end
            if (i_cfg_idx == REG_HOOK_MODE) begin
                r_cfg.hook_mode <= i_cfg_data[0];
            end
            for (int i = 0; i < NUM_THRESHOLDS; i++) begin
                if (i_cfg_idx == REG_THRESHOLD_0 + CFG_IDX_W'(i)) begin
                    r_thr[i] <= i_cfg_data[CNT_W-1:0];
                end
            end
        end
    end

    assign o_cfg = r_cfg;
    assign o_thr = r_thr;

endmodule

// ----- rtl/core/psc_engine.sv -----
module psc_engine #(
    parameter int TABLE_ENTRIES = psc_pkg::DEF_TABLE_ENTRIES,
    parameter int NUM_THRESHOLDS = psc_pkg::DEF_NUM_THRESHOLDS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          start,
    output logic                                          busy,
    input  psc_pkg::t_req                                 i_req,
    input  psc_pkg::t_cfg                                 i_cfg,
    input  logic [NUM_THRESHOLDS-1:0][psc_pkg::CNT_W-1:0] i_thr,
    output logic                                          o_valid,
    output psc_pkg::t_rsp                                 o_result
);
    import psc_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = IPADDR_W + CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pidx, n_pidx;
    logic [AW-1:0]       r_slot, n_slot;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_alloc, n_alloc;
    logic                r_est, n_est;
    logic [IPADDR_W-1:0] r_addr, n_addr;
    logic                r_valid, n_valid;
    t_rsp                r_rsp, n_rsp;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_wdata, ram_rdata;

    logic                hit, active, match, thr_hit, inc_ok;
    logic [CNT_W-1:0]    cnt_inc, cnt_upd;
    logic                kick;

    psc_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy = (r_state != S_IDLE);
    assign hit = (i_req.dest_port == i_cfg.listen_port) ||
                 (i_req.source_port == i_cfg.listen_port);
    assign active = hit && ((i_req.conn_event == EV_ESTABLISHED) ||
                            (i_req.conn_event == EV_RELEASED));
    assign match = r_pend && (ram_rdata[EW-1:CNT_W] == r_addr);

    // update unit: step, threshold compare
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign inc_ok = (r_cnt != '1);
    always_comb begin
        thr_hit = 1'b0;
        for (int i = 0; i < NUM_THRESHOLDS; i++) begin
            if ((i_thr[i] != '0) && (i_thr[i] == cnt_inc)) begin
                thr_hit = 1'b1;
            end
        end
    end

    always_comb begin
        kick = 1'b0;
        if (r_est) begin
            cnt_upd = inc_ok ? cnt_inc : r_cnt;
            kick = inc_ok && !i_cfg.hook_mode && thr_hit;
        end else begin
            cnt_upd = (r_cnt != '0) ? r_cnt - CNT_W'(1) : r_cnt;
        end
    end

    assign ram_we = (r_state == S_UPDATE);
    assign ram_wdata = {r_addr, cnt_upd};
    assign ram_raddr = r_idx[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_fill = r_fill;
        n_idx = r_idx;
        n_pend = r_pend;
        n_pidx = r_pidx;
        n_slot = r_slot;
        n_cnt = r_cnt;
        n_alloc = r_alloc;
        n_est = r_est;
        n_addr = r_addr;
        n_valid = 1'b0;
        n_rsp = r_rsp;
        ram_re = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (active) begin
                        n_state = S_SCAN;
                        n_idx = '0;
                        n_pend = 1'b0;
                        n_addr = i_req.server_addr;
                        n_est = (i_req.conn_event == EV_ESTABLISHED);
                    end else begin
                        n_valid = 1'b1;
                        n_rsp = '0;
                        n_rsp.port_hit = hit;
                    end
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_slot = r_pidx;
                    n_cnt = ram_rdata[CNT_W-1:0];
                    n_alloc = 1'b0;
                    n_state = S_UPDATE;
                end else if (r_idx == r_fill) begin
                    n_pend = 1'b0;
                    if (r_fill == CW'(TABLE_ENTRIES)) begin
                        n_valid = 1'b1;
                        n_rsp = '0;
                        n_rsp.port_hit = 1'b1;
                        n_rsp.table_full = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_slot = r_fill[AW-1:0];
                        n_cnt = '0;
                        n_alloc = 1'b1;
                        n_state = S_UPDATE;
                    end
                end else begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx = r_idx + CW'(1);
                end
            end
            S_UPDATE: begin
                if (r_alloc) begin
                    n_fill = r_fill + CW'(1);
                end
                n_pend = 1'b0;
                n_valid = 1'b1;
                n_rsp.port_hit = 1'b1;
                n_rsp.kick = kick;
                n_rsp.current_count = cnt_upd;
                n_rsp.addr_echo = r_addr;
                n_rsp.table_full = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_pend <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            r_pend <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pidx <= n_pidx;
        r_slot <= n_slot;
        r_cnt <= n_cnt;
        r_alloc <= n_alloc;
        r_est <= n_est;
        r_addr <= n_addr;
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_result = r_rsp;

endmodule

// ----- rtl/core/psc_checker.sv -----
module psc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input psc_pkg::t_rsp o_result
);

    // a result only follows an accepted request or ongoing work
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result without request");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.table_full |->
            !o_result.kick && (o_result.current_count == '0) &&
            (o_result.addr_echo == '0) && o_result.port_hit)
        else $error("table full result carries data");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.port_hit |->
            !o_result.kick && !o_result.table_full &&
            (o_result.current_count == '0) && (o_result.addr_echo == '0))
        else $error("unmatched request changed state");

    a_kick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kick |-> (o_result.current_count != '0))
        else $error("kick on zero count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("not idle after reset");

endmodule

bind per_server_connection_counter psc_checker u_psc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// ----- sim/conn_count_checker.sv -----
`timescale 1ns / 100ps
module conn_count_checker #(
    parameter int TABLE_ENTRIES = psc_pkg::DEF_TABLE_ENTRIES,
    parameter int NUM_THRESHOLDS = psc_pkg::DEF_NUM_THRESHOLDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  psc_pkg::t_req                  i_req,
    input  logic                           i_valid,
    input  psc_pkg::t_rsp                  i_result,
    input  logic                           i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_kicks,
    output int                             o_fulls,
    output int                             o_saturated
);
    import psc_pkg::*;

    logic [PORT_W-1:0]   listen_port_q;
    logic                min_mode;
    logic [CNT_W-1:0]    thr [MAX_THRESHOLDS];

    logic                slot_used  [TABLE_ENTRIES];
    logic [IPADDR_W-1:0] slot_addr  [TABLE_ENTRIES];
    logic [CNT_W-1:0]    slot_conns [TABLE_ENTRIES];

    t_rsp awaited_updates[$];
    t_rsp want;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
        o_kicks = 0;
        o_fulls = 0;
        o_saturated = 0;
    end

    function automatic logic hits_threshold(input logic [CNT_W-1:0] c);
        for (int k = 0; k < NUM_THRESHOLDS && k < MAX_THRESHOLDS; k++) begin
            if (thr[k] != '0 && thr[k] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    // updates the server table and returns the result the request must produce
    function automatic t_rsp count_event(input t_req r);
        t_rsp rsp;
        int slot;
        logic [CNT_W-1:0] c;
        rsp = '0;
        slot = -1;
        rsp.port_hit = (r.dest_port == listen_port_q) || (r.source_port == listen_port_q);
        if (rsp.port_hit && (r.conn_event == EV_ESTABLISHED || r.conn_event == EV_RELEASED)) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot < 0 && slot_used[i] && slot_addr[i] == r.server_addr) slot = i;
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot < 0 && !slot_used[i]) begin
                    slot = i;
                    slot_used[i] = 1'b1;
                    slot_addr[i] = r.server_addr;
                    slot_conns[i] = '0;
                end
            end
            if (slot < 0) begin
                rsp.table_full = 1'b1;
            end else begin
                c = slot_conns[slot];
                if (r.conn_event == EV_ESTABLISHED) begin
                    if (c != '1) begin
                        c = c + 1'b1;
                        rsp.kick = !min_mode && hits_threshold(c);
                    end
                end else if (c != '0) begin
                    c = c - 1'b1;
                end
                slot_conns[slot] = c;
                rsp.current_count = c;
                rsp.addr_echo = r.server_addr;
            end
        end
        return rsp;
    endfunction

    function automatic void check_field(input string name, input logic [IPADDR_W-1:0] exp_v,
                                        input logic [IPADDR_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            listen_port_q = '0;
            min_mode = 1'b0;
            for (int k = 0; k < MAX_THRESHOLDS; k++) thr[k] = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
            awaited_updates.delete();
        end else begin
            if (i_valid) begin
                if (awaited_updates.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %h", $time, i_result);
                    o_fail_count++;
                end else begin
                    want = awaited_updates.pop_front();
                    check_field("port_hit", want.port_hit, i_result.port_hit);
                    check_field("kick", want.kick, i_result.kick);
                    check_field("current_count", want.current_count, i_result.current_count);
                    check_field("addr_echo", want.addr_echo, i_result.addr_echo);
                    check_field("table_full", want.table_full, i_result.table_full);
                    o_checked++;
                    if (want.kick) o_kicks++;
                    if (want.table_full) o_fulls++;
                    if (want.current_count == '1) o_saturated++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LISTEN_PORT: begin
                        listen_port_q = i_cfg_data;
                    end
                    REG_HOOK_MODE: begin
                        min_mode = i_cfg_data[0];
                    end
                    default: begin
                        if (i_cfg_idx >= REG_THRESHOLD_0
                                && i_cfg_idx < REG_THRESHOLD_0 + MAX_THRESHOLDS)
                            thr[2'(i_cfg_idx - REG_THRESHOLD_0)] = i_cfg_data;
                    end
                endcase
            end
            if (i_start && !i_busy) awaited_updates.push_back(count_event(i_req));
        end
        o_pending = awaited_updates.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;
    import psc_pkg::*;

    localparam int ENTRIES = DEF_TABLE_ENTRIES;
    localparam int THRESHOLDS = DEF_NUM_THRESHOLDS;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [EV_W-1:0] EV_SPARE = 2'd3;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_EVENTS = 90;
    localparam int CLIMB_EVENTS = 300;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = ENTRIES + 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_req                  req;
    logic                  rsp_valid;
    t_rsp                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count, pending, checked, kicks, fulls, saturated;
    int stall_cycles = 0;

    logic [IPADDR_W-1:0] addr_pool [ENTRIES];
    logic [CNT_W-1:0]    thr_plan  [MAX_THRESHOLDS];
    logic [PORT_W-1:0]   port;
    logic                mode;
    t_req                r;
    int                  counted;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    per_server_connection_counter #(
        .TABLE_ENTRIES(ENTRIES),
        .NUM_THRESHOLDS(THRESHOLDS)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .start(start),
        .busy(busy),
        .i_req(req),
        .o_valid(rsp_valid),
        .o_result(rsp),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    conn_count_checker #(
        .TABLE_ENTRIES(ENTRIES),
        .NUM_THRESHOLDS(THRESHOLDS)
    ) u_check (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_req(req),
        .i_valid(rsp_valid),
        .i_result(rsp),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked),
        .o_kicks(kicks),
        .o_fulls(fulls),
        .o_saturated(saturated)
    );

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || rsp_valid || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_req mk_req(input logic [PORT_W-1:0] dport, input logic [PORT_W-1:0] sport,
                                    input logic [IPADDR_W-1:0] addr, input logic [EV_W-1:0] ev);
        t_req q;
        q.dest_port = dport;
        q.source_port = sport;
        q.server_addr = addr;
        q.conn_event = ev;
        return q;
    endfunction

    function automatic t_req random_event(input logic [PORT_W-1:0] lport, input bit fresh_ok);
        t_req q;
        int pick;
        q.dest_port = PORT_W'($urandom_range(0, 65535));
        q.source_port = PORT_W'($urandom_range(0, 65535));
        q.server_addr = addr_pool[$urandom_range(0, ENTRIES - 1)];
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            q.dest_port = lport;
        end else if (pick < 6) begin
            q.source_port = lport;
        end else if (pick == 6) begin
            q.dest_port = lport;
            q.source_port = lport;
        end
        pick = $urandom_range(0, 19);
        if (pick < 9) q.conn_event = EV_ESTABLISHED;
        else if (pick < 17) q.conn_event = EV_RELEASED;
        else if (pick < 19) q.conn_event = EV_NONE;
        else q.conn_event = EV_SPARE;
        // occasional unknown server, rejected once the table is full
        if (fresh_ok && $urandom_range(0, 11) == 0) q.server_addr = $urandom;
        return q;
    endfunction

    // request is held until taken, then start may drop for a random gap
    task automatic post_event(input t_req q, input int gap);
        @(negedge clk);
        req = q;
        start = 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        if (gap > 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0 || busy !== 1'b0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_phase(input logic [PORT_W-1:0] lport, input logic min_mode);
        settle();
        write_reg(REG_LISTEN_PORT, lport);
        write_reg(REG_HOOK_MODE, CFG_DATA_W'(min_mode));
        for (int k = 0; k < MAX_THRESHOLDS; k++)
            write_reg(REG_THRESHOLD_0 + CFG_IDX_W'(k), thr_plan[k]);
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < ENTRIES; i++) addr_pool[i] = $urandom;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: port extremes, no-event codes, release floor, kicks
        thr_plan = '{16'd1, 16'd3, 16'd0, 16'hFFFF};
        set_phase(16'hFFFF, 1'b0);
        write_reg(REG_SPARE_A, 16'h1234);
        write_reg(REG_SPARE_B, 16'hFFFF);
        post_event(mk_req(16'hFFFF, 16'h0000, 32'h0, EV_ESTABLISHED), 0);
        post_event(mk_req(16'h0000, 16'hFFFF, 32'h0, EV_ESTABLISHED), 0);
        post_event(mk_req(16'hFFFF, 16'hFFFF, 32'h0, EV_ESTABLISHED), 0);
        post_event(mk_req(16'hFFFE, 16'h7FFF, 32'h0, EV_ESTABLISHED), 0);
        post_event(mk_req(16'hFFFF, 16'h1234, 32'h0, EV_NONE), 0);
        post_event(mk_req(16'h4321, 16'hFFFF, 32'h0, EV_SPARE), 0);
        post_event(mk_req(16'hFFFF, 16'h0001, 32'hFFFF_FFFF, EV_RELEASED), 0);
        post_event(mk_req(16'hFFFF, 16'h0001, 32'hFFFF_FFFF, EV_RELEASED), 0);
        post_event(mk_req(16'h8000, 16'hFFFF, 32'h0, EV_RELEASED), 0);
        post_event(mk_req(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, EV_ESTABLISHED), 0);
        post_event(mk_req(16'hFFFF, 16'h0000, 32'h0, EV_ESTABLISHED), 0);
        set_phase(16'hFFFF, 1'b1);
        post_event(mk_req(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, EV_ESTABLISHED), 0);
        post_event(mk_req(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, EV_ESTABLISHED), 0);
        thr_plan = '{16'd2, 16'd4, 16'd5, 16'd0};
        set_phase(16'h0000, 1'b0);
        post_event(mk_req(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, EV_RELEASED), 0);
        post_event(mk_req(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, EV_ESTABLISHED), 0);
        post_event(mk_req(16'hFFFF, 16'hFFFF, 32'h0, EV_ESTABLISHED), 0);

        // drive one server up a long run of increments, kick on a distant threshold
        thr_plan = '{CNT_W'(CLIMB_EVENTS), 16'd0, 16'd0, 16'd0};
        set_phase(16'h0050, 1'b0);
        for (int n = 0; n < CLIMB_EVENTS; n++)
            post_event(mk_req(16'h0050, 16'h0000, 32'h0, EV_ESTABLISHED), 0);
        post_event(mk_req(16'h0050, 16'h0000, 32'h0, EV_RELEASED), 0);
        post_event(mk_req(16'h0000, 16'h0050, 32'h0, EV_ESTABLISHED), 0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 1) port = 16'h0000;
            else if (p == 2) port = 16'hFFFF;
            else port = PORT_W'($urandom_range(0, 65535));
            mode = (p == 1) ? 1'b1 : (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            for (int k = 0; k < MAX_THRESHOLDS; k++) begin
                if (p == 2) thr_plan[k] = '0;
                else if ($urandom_range(0, 7) == 0) thr_plan[k] = CNT_W'($urandom_range(0, 65535));
                else thr_plan[k] = CNT_W'($urandom_range(0, 12));
            end
            set_phase(port, mode);
            counted = 0;
            while (counted < PHASE_EVENTS) begin
                r = random_event(port, p > 0);
                if ((r.dest_port == port || r.source_port == port)
                        && (r.conn_event == EV_ESTABLISHED || r.conn_event == EV_RELEASED))
                    counted++;
                post_event(r, (p < RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0)
                              ? $urandom_range(1, 12) : 0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("%0d results checked, incl. %0d kicks, %0d table-full rejects,", checked, kicks,
                 fulls);
        $display("%0d results at the count ceiling; %0d failures", saturated, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
